/* sv/ffha_pkg.sv */
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

    localparam int HDR_W   = 8;
    localparam int SMIN_W  = 16;
    localparam int LIM_W   = 25;
    localparam int BYTES_W = 25;
    localparam int REQ_W   = 24;
    localparam int OFF_W   = 24;
    localparam int ST_W    = 3;
    localparam int CALLS_W = 32;
    localparam int START_W = 26;
    localparam int IN_W    = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [HDR_W-1:0]  HDR_RST  = 8'd24;
    localparam logic [SMIN_W-1:0] SMIN_RST = 16'd25;
    localparam logic [LIM_W-1:0]  LIM_RST  = 25'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MINIMUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT    = 2'd2;

    localparam logic [ST_W-1:0] ST_OK           = 3'd0;
    localparam logic [ST_W-1:0] ST_ZERO_SIZE    = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_SPACE     = 3'd2;
    localparam logic [ST_W-1:0] ST_INVALID_FREE = 3'd3;
    localparam logic [ST_W-1:0] ST_DOUBLE_FREE  = 3'd4;
    localparam logic [ST_W-1:0] ST_TABLE_FULL   = 3'd5;

    typedef enum logic [1:0] {
        RD_SCAN  = 2'd0,
        RD_NEXT  = 2'd1,
        RD_SHIFT = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        t_rd_sel rd_sel;
        logic    no_hit;
        logic    scan_eval;
        logic    nb_eval;
        logic    merge;
        logic    shift_wr;
        logic    ins_wr;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        logic alloc;
        logic zero;
        logic scan_end;
        logic hit;
        logic hit_used;
        logic has_next;
        logic shift_go;
        logic split;
        logic shift_last;
    } t_stat;

endpackage

/* sv/ffha_ram.sv */
// generic simple dual-port ram with registered read
module ffha_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ffha_datapath.sv */
// block table, heap registers and result registers of the allocator
module ffha_datapath #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ffha_pkg::LIM_W-1:0]       i_cfg_data,
    input  logic                             i_action,
    input  logic [ffha_pkg::REQ_W-1:0]       i_request_bytes,
    input  logic [ffha_pkg::OFF_W-1:0]       i_release_offset,
    input  ffha_pkg::t_cmd                   i_cmd,
    output ffha_pkg::t_stat                  o_stat,
    output logic [ffha_pkg::OFF_W-1:0]       o_payload_offset,
    output logic [ffha_pkg::ST_W-1:0]        o_status,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]  o_used_blocks,
    output logic [ffha_pkg::CALLS_W-1:0]     o_allocate_calls
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS+1);
    localparam int BW = ffha_pkg::BYTES_W;
    localparam int EW = BW + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);

    // configuration
    logic [ffha_pkg::HDR_W-1:0]  r_hdr;
    logic [ffha_pkg::SMIN_W-1:0] r_smin;
    logic [ffha_pkg::LIM_W-1:0]  r_lim;

    // persistent state
    logic [CW-1:0]                r_total;
    logic [BW-1:0]                r_heap;
    logic [ffha_pkg::CALLS_W-1:0] r_calls;
    logic [CW-1:0]                r_used;

    // per-request working registers
    logic                          r_alloc;
    logic [ffha_pkg::REQ_W-1:0]    r_req;
    logic [ffha_pkg::OFF_W-1:0]    r_rel;
    logic [BW-1:0]                 r_size;
    logic [CW-1:0]                 r_idx;
    logic [ffha_pkg::START_W-1:0]  r_start;
    logic                          r_prev_used;
    logic [BW-1:0]                 r_prev_bytes;
    logic [BW-1:0]                 r_cur;
    logic                          r_right;
    logic [CW-1:0]                 r_pos;
    logic [CW-1:0]                 r_src;
    logic [CW-1:0]                 r_last;
    logic                          r_up;
    logic [1:0]                    r_gap;
    logic                          r_split;
    logic                          r_shift_go;
    logic [ffha_pkg::OFF_W-1:0]    r_res_off;
    logic [ffha_pkg::ST_W-1:0]     r_res_st;

    // output registers
    logic [ffha_pkg::OFF_W-1:0]    r_out_off;
    logic [ffha_pkg::ST_W-1:0]     r_out_st;
    logic [CW-1:0]                 r_out_used;
    logic [ffha_pkg::CALLS_W-1:0]  r_out_calls;

    // ram port signals
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [EW-1:0] w_rdata;

    logic                  rd_used;
    logic [BW-1:0]         rd_bytes;
    logic [26:0]           hdr_pos;
    logic                  alloc_fit;
    logic                  free_match;
    logic [BW-1:0]         left;
    logic                  do_split;
    logic [CW:0]           idx_p1;
    logic                  mg_left;
    logic [CW-1:0]         mg_pos;
    logic [BW-1:0]         mg_bytes;
    logic [1:0]            mg_r;
    logic [CW-1:0]         mg_total;
    logic [CW:0]           mg_src;
    logic                  mg_last_blk;
    logic [BW:0]           ap_sum;
    logic                  ap_nospace;
    logic                  ap_full;
    logic [CW-1:0]         sh_dst;

    assign rd_used    = w_rdata[BW];
    assign rd_bytes   = w_rdata[BW-1:0];
    assign hdr_pos    = {1'b0, r_start} + 27'(r_hdr);
    assign alloc_fit  = r_alloc && !rd_used && (rd_bytes >= r_size);
    assign free_match = !r_alloc && (hdr_pos == 27'(r_rel));
    assign left       = rd_bytes - r_size;
    assign do_split   = (left != '0) && (left >= BW'(r_smin)) && (r_total < MAX_CNT);
    assign idx_p1     = {1'b0, r_idx} + (CW+1)'(1);

    // merge: right neighbor already folded into r_cur, left one folded here
    assign mg_left     = (r_idx != '0) && !r_prev_used;
    assign mg_pos      = r_idx - CW'(mg_left);
    assign mg_bytes    = mg_left ? (r_prev_bytes + r_cur) : r_cur;
    assign mg_r        = {1'b0, r_right} + {1'b0, mg_left};
    assign mg_total    = r_total - CW'(mg_r);
    assign mg_src      = idx_p1 + (CW+1)'(r_right);
    assign mg_last_blk = (({1'b0, mg_pos}) + (CW+1)'(1)) == {1'b0, mg_total};

    assign ap_sum     = {1'b0, r_heap} + {1'b0, r_size};
    assign ap_nospace = ap_sum > {1'b0, r_lim};
    assign ap_full    = r_total >= MAX_CNT;

    assign sh_dst = r_up ? (r_src + CW'(1)) : (r_src - CW'(r_gap));

    // read address select
    always_comb begin
        case (i_cmd.rd_sel)
            ffha_pkg::RD_SCAN:  w_raddr = r_idx[AW-1:0];
            ffha_pkg::RD_NEXT:  w_raddr = idx_p1[AW-1:0];
            ffha_pkg::RD_SHIFT: w_raddr = r_src[AW-1:0];
            default:            w_raddr = r_idx[AW-1:0];
        endcase
    end

    // write port select
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        if (i_cmd.no_hit && r_alloc && !ap_nospace && !ap_full) begin
            w_we    = 1'b1;
            w_waddr = r_total[AW-1:0];
            w_wdata = {1'b1, r_size};
        end else if (i_cmd.scan_eval && alloc_fit) begin
            w_we    = 1'b1;
            w_waddr = r_idx[AW-1:0];
            w_wdata = {1'b1, do_split ? r_size : rd_bytes};
        end else if (i_cmd.merge && !mg_last_blk) begin
            w_we    = 1'b1;
            w_waddr = mg_pos[AW-1:0];
            w_wdata = {1'b0, mg_bytes};
        end else if (i_cmd.shift_wr) begin
            w_we    = 1'b1;
            w_waddr = sh_dst[AW-1:0];
            w_wdata = w_rdata;
        end else if (i_cmd.ins_wr) begin
            w_we    = 1'b1;
            w_waddr = r_pos[AW-1:0];
            w_wdata = {1'b0, r_cur};
        end
    end

    ffha_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr  <= ffha_pkg::HDR_RST;
            r_smin <= ffha_pkg::SMIN_RST;
            r_lim  <= ffha_pkg::LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ffha_pkg::CFG_HEADER_BYTES:  r_hdr  <= i_cfg_data[ffha_pkg::HDR_W-1:0];
                ffha_pkg::CFG_SPLIT_MINIMUM: r_smin <= i_cfg_data[ffha_pkg::SMIN_W-1:0];
                ffha_pkg::CFG_HEAP_LIMIT:    r_lim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // persistent table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_heap  <= '0;
            r_calls <= '0;
            r_used  <= '0;
        end else begin
            if (i_cmd.load && !i_action && (r_calls != '1)) begin
                r_calls <= r_calls + 1'b1;
            end
            if (i_cmd.no_hit && r_alloc && !ap_nospace && !ap_full) begin
                r_total <= r_total + 1'b1;
                r_used  <= r_used + 1'b1;
                r_heap  <= ap_sum[BW-1:0];
            end
            if (i_cmd.scan_eval && alloc_fit) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.merge) begin
                r_used <= r_used - 1'b1;
                if (mg_last_blk) begin
                    r_total <= mg_total - 1'b1;
                    r_heap  <= r_heap - mg_bytes;
                end else begin
                    r_total <= mg_total;
                end
            end
            if (i_cmd.ins_wr) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_alloc     <= !i_action;
            r_req       <= i_request_bytes;
            r_rel       <= i_release_offset;
            r_size      <= BW'(i_request_bytes) + BW'(r_hdr);
            r_idx       <= '0;
            r_start     <= '0;
            r_prev_used <= 1'b1;
            r_right     <= 1'b0;
            r_split     <= 1'b0;
            r_shift_go  <= 1'b0;
            r_res_off   <= '0;
            r_res_st    <= (!i_action && (i_request_bytes == '0)) ?
                           ffha_pkg::ST_ZERO_SIZE : ffha_pkg::ST_OK;
        end
        if (i_cmd.no_hit) begin
            if (r_alloc) begin
                if (ap_nospace) begin
                    r_res_st <= ffha_pkg::ST_NO_SPACE;
                end else if (ap_full) begin
                    r_res_st <= ffha_pkg::ST_TABLE_FULL;
                end else begin
                    r_res_off <= ffha_pkg::OFF_W'(r_heap + BW'(r_hdr));
                end
            end else if (r_rel != '0) begin
                r_res_st <= ffha_pkg::ST_INVALID_FREE;
            end
        end
        if (i_cmd.scan_eval) begin
            if (alloc_fit) begin
                r_res_off <= hdr_pos[ffha_pkg::OFF_W-1:0];
                if (do_split) begin
                    r_split    <= 1'b1;
                    r_cur      <= left;
                    r_pos      <= idx_p1[CW-1:0];
                    r_src      <= r_total - 1'b1;
                    r_last     <= idx_p1[CW-1:0];
                    r_up       <= 1'b1;
                    r_shift_go <= idx_p1 < {1'b0, r_total};
                end
            end else if (free_match) begin
                if (!rd_used) begin
                    r_res_st <= ffha_pkg::ST_DOUBLE_FREE;
                end else begin
                    r_cur <= rd_bytes;
                end
            end else begin
                r_start      <= r_start + ffha_pkg::START_W'(rd_bytes);
                r_prev_used  <= rd_used;
                r_prev_bytes <= rd_bytes;
                r_idx        <= r_idx + 1'b1;
            end
        end
        if (i_cmd.nb_eval) begin
            r_right <= !rd_used;
            if (!rd_used) begin
                r_cur <= r_cur + rd_bytes;
            end
        end
        if (i_cmd.merge && !mg_last_blk) begin
            r_src      <= mg_src[CW-1:0];
            r_last     <= r_total - 1'b1;
            r_up       <= 1'b0;
            r_gap      <= mg_r;
            r_shift_go <= (mg_r != '0) && (mg_src < {1'b0, r_total});
        end
        if (i_cmd.shift_wr && (r_src != r_last)) begin
            r_src <= r_up ? (r_src - 1'b1) : (r_src + 1'b1);
        end
    end

    // result register toward the output side
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_off   <= r_res_off;
            r_out_st    <= r_res_st;
            r_out_used  <= r_used;
            r_out_calls <= r_calls;
        end
    end

    assign o_stat.alloc      = r_alloc;
    assign o_stat.zero       = r_alloc && (r_req == '0);
    assign o_stat.scan_end   = r_idx == r_total;
    assign o_stat.hit        = alloc_fit || free_match;
    assign o_stat.hit_used   = rd_used;
    assign o_stat.has_next   = idx_p1 < {1'b0, r_total};
    assign o_stat.shift_go   = r_shift_go;
    assign o_stat.split      = r_split;
    assign o_stat.shift_last = r_src == r_last;

    assign o_payload_offset = r_out_off;
    assign o_status         = r_out_st;
    assign o_used_blocks    = r_out_used;
    assign o_allocate_calls = r_out_calls;

endmodule

/* sv/ffha_ctrl.sv */
// sequencing state machine of the allocator
module ffha_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_cmd  o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_SCAN_RD = 11'b000_0000_0010,
        S_SCAN_EV = 11'b000_0000_0100,
        S_NB_RD   = 11'b000_0000_1000,
        S_NB_EV   = 11'b000_0001_0000,
        S_MERGE   = 11'b000_0010_0000,
        S_POST    = 11'b000_0100_0000,
        S_SH_RD   = 11'b000_1000_0000,
        S_SH_WR   = 11'b001_0000_0000,
        S_INS_WR  = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = ffha_pkg::RD_SCAN;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_stat.zero) begin
                    n_state = S_DONE;
                end else if (i_stat.scan_end) begin
                    o_cmd.no_hit = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                o_cmd.scan_eval = 1'b1;
                if (!i_stat.hit) begin
                    n_state = S_SCAN_RD;
                end else if (i_stat.alloc) begin
                    n_state = S_POST;
                end else if (!i_stat.hit_used) begin
                    n_state = S_DONE;
                end else if (i_stat.has_next) begin
                    n_state = S_NB_RD;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_NB_RD: begin
                o_cmd.rd_sel = ffha_pkg::RD_NEXT;
                n_state      = S_NB_EV;
            end
            S_NB_EV: begin
                o_cmd.nb_eval = 1'b1;
                n_state       = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = S_POST;
            end
            S_POST: begin
                if (i_stat.shift_go) begin
                    n_state = S_SH_RD;
                end else if (i_stat.split) begin
                    n_state = S_INS_WR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SH_RD: begin
                o_cmd.rd_sel = ffha_pkg::RD_SHIFT;
                n_state      = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.shift_wr = 1'b1;
                if (!i_stat.shift_last) begin
                    n_state = S_SH_RD;
                end else if (i_stat.split) begin
                    n_state = S_INS_WR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS_WR: begin
                o_cmd.ins_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // wait here while the output register still holds a result
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* sv/first_fit_heap_allocator_unit.sv */
// top level of the first-fit heap allocator with split and coalesce
//
//  channel  | direction | tdata (low bit up)                          | tuser
//  s_axis   | in        | request_bytes[23:0], release_offset[47:24]  | action[0]
//  m_axis   | out       | payload_offset, status, used_blocks, calls  | -
//  i_cfg_*  | in        | write enable, register index, write data    | -
//
// one request at a time; the walk over table entries and the entries moved by
// a split or merge both go through the single registered-read table ram. a
// zero-size allocate goes straight to the result without walking the table.
// reset is synchronous; the table ram has no clearing pass, only its count is
// reset. a finished result waits in the last state while the output register
// is still full, which stalls input.
module first_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ffha_pkg::IN_W-1:0]           s_axis_tdata,  // request_bytes, release_offset
    input  logic [0:0]                          s_axis_tuser,  // action
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // payload_offset, status, used_blocks, allocate_calls, zero fill
    output logic [((59 + $clog2(MAX_BLOCKS+1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ffha_pkg::LIM_W-1:0]          i_cfg_data
);

    localparam int CW    = $clog2(MAX_BLOCKS+1);
    localparam int ST_LO = ffha_pkg::OFF_W;
    localparam int US_LO = ST_LO + ffha_pkg::ST_W;
    localparam int CA_LO = US_LO + CW;

    ffha_pkg::t_cmd  w_cmd;
    ffha_pkg::t_stat w_stat;

    logic [ffha_pkg::OFF_W-1:0]   w_off;
    logic [ffha_pkg::ST_W-1:0]    w_st;
    logic [CW-1:0]                w_used;
    logic [ffha_pkg::CALLS_W-1:0] w_calls;

    // sequencer
    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // table, heap bookkeeping and result register
    ffha_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_action         (s_axis_tuser[0]),
        .i_request_bytes  (s_axis_tdata[ffha_pkg::REQ_W-1:0]),
        .i_release_offset (s_axis_tdata[ffha_pkg::IN_W-1:ffha_pkg::REQ_W]),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_payload_offset (w_off),
        .o_status         (w_st),
        .o_used_blocks    (w_used),
        .o_allocate_calls (w_calls)
    );

    // pack the result transfer
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[ST_LO-1:0]                     = w_off;
        m_axis_tdata[US_LO-1:ST_LO]                 = w_st;
        m_axis_tdata[CA_LO-1:US_LO]                 = w_used;
        m_axis_tdata[CA_LO+ffha_pkg::CALLS_W-1:CA_LO] = w_calls;
    end

endmodule
